[rtl/antialiased_corner_pixel_blend_defines.svh]
// ----------------------------------------------------------------------------
// Antialiased corner pixel blend assertion macros
// Shared assertion wrappers for the checker of the corner blend block.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_CORNER_PIXEL_BLEND_DEFINES_SVH
`define ANTIALIASED_CORNER_PIXEL_BLEND_DEFINES_SVH

// Assertion that is switched off while reset is asserted.
`define ACPB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define ACPB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/acpb_pkg.sv]
// ----------------------------------------------------------------------------
// Antialiased corner pixel blend package
// Item types, root chain record and sizing constants of the corner blend.
// ----------------------------------------------------------------------------
package acpb_pkg;

    localparam logic [7:0] MAX_RADIUS = 8'd127;

    localparam int RAD_N_W = 24;
    localparam int ROOT_W  = RAD_N_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int CELLS   = ROOT_W;

    typedef struct packed {
        logic        operation;
        logic [6:0]  corner_dx;
        logic [6:0]  corner_dy;
        logic [6:0]  radius;
        logic [7:0]  alpha;
        logic [15:0] source_color;
        logic [15:0] dest_color;
    } t_in_item;

    typedef struct packed {
        logic [15:0] blended_color;
        logic [7:0]  coverage;
        logic        write_pixel;
    } t_out_item;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [RAD_N_W-1:0] rad;
        t_in_item           pix;
    } t_cell;

endpackage

[rtl/acpb_root_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the floor square root: takes two radicand bits and
// decides one root bit, then hands the record to the next cell.
// ----------------------------------------------------------------------------
module acpb_root_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  acpb_pkg::t_cell i_data,
    output logic           o_valid,
    output acpb_pkg::t_cell o_data
);

    logic                           r_valid;
    acpb_pkg::t_cell                r_data;
    acpb_pkg::t_cell                n_data;
    logic [acpb_pkg::REM_W-1:0]     rem_s;
    logic [acpb_pkg::REM_W-1:0]     trial;

    always_comb begin
        rem_s  = {i_data.rem[acpb_pkg::REM_W-3:0], i_data.rad[acpb_pkg::RAD_N_W-1 -: 2]};
        trial  = {i_data.root, 2'b01};
        n_data = i_data;
        n_data.rad = {i_data.rad[acpb_pkg::RAD_N_W-3:0], 2'b00};
        if (rem_s >= trial) begin
            n_data.rem  = rem_s - trial;
            n_data.root = {i_data.root[acpb_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_s;
            n_data.root = {i_data.root[acpb_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/acpb_blend.sv]
// ----------------------------------------------------------------------------
// Coverage and blend stages
// Turns the distance into fill or outline coverage, scales the shape alpha
// and blends the RGB565 channels into the output register.
// ----------------------------------------------------------------------------
module acpb_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  acpb_pkg::t_cell     i_data,
    output logic                o_valid,
    output acpb_pkg::t_out_item o_item
);

    function automatic logic [7:0] fill_cov(input logic signed [12:0] c);
        logic [11:0] prod;
        prod = {c[3:0], 8'h00} - {8'h00, c[3:0]};
        if (c <= 13'sd0) begin
            fill_cov = 8'd0;
        end else if (c >= 13'sd16) begin
            fill_cov = 8'd255;
        end else begin
            fill_cov = prod[11:4];
        end
    endfunction

    function automatic logic [5:0] div255(input logic [13:0] t);
        logic [14:0] s;
        s = {1'b0, t} + {9'b0, t[13:8]} + 15'd1;
        div255 = s[13:8];
    endfunction

    // Coverage stage.
    logic               r_c_valid;
    logic [7:0]         r_c_cov;
    logic [7:0]         r_c_alpha;
    logic [15:0]        r_c_src;
    logic [15:0]        r_c_dst;
    logic [11:0]        base;
    logic signed [12:0] c_out;
    logic signed [12:0] c_in;
    logic [7:0]         n_c_cov;

    always_comb begin
        base  = {1'b0, i_data.pix.radius, 4'b0000} + 12'd8;
        c_out = $signed({1'b0, base}) - $signed({1'b0, i_data.root});
        c_in  = c_out - 13'sd16;
        if (i_data.pix.operation) begin
            n_c_cov = fill_cov(c_out) - fill_cov(c_in);
        end else begin
            n_c_cov = fill_cov(c_out);
        end
    end

    // Pixel alpha stage: floor(x/255) is exact as ((x+1)*257)>>16 below 65535.
    logic        r_p_valid;
    logic [7:0]  r_p_cov;
    logic [7:0]  r_p_alpha;
    logic [15:0] r_p_src;
    logic [15:0] r_p_dst;
    logic [15:0] cov_alpha;
    logic [16:0] x1;
    logic [24:0] y;

    always_comb begin
        cov_alpha = r_c_cov * r_c_alpha;
        x1 = {1'b0, cov_alpha} + 17'd1;
        y  = {x1, 8'h00} + {8'h00, x1};
    end

    // Blend stage and output register.
    logic                r_o_valid;
    acpb_pkg::t_out_item r_o_item;
    acpb_pkg::t_out_item n_o_item;
    logic [7:0]          ia;
    logic [13:0]         t_r;
    logic [13:0]         t_g;
    logic [13:0]         t_b;
    logic [5:0]          q_r;
    logic [5:0]          q_g;
    logic [5:0]          q_b;

    always_comb begin
        ia  = 8'hFF - r_p_alpha;
        t_r = 14'(r_p_src[15:11] * r_p_alpha) + 14'(r_p_dst[15:11] * ia);
        t_g = 14'(r_p_src[10:5] * r_p_alpha) + 14'(r_p_dst[10:5] * ia);
        t_b = 14'(r_p_src[4:0] * r_p_alpha) + 14'(r_p_dst[4:0] * ia);
        q_r = div255(t_r);
        q_g = div255(t_g);
        q_b = div255(t_b);
        n_o_item.coverage    = r_p_cov;
        n_o_item.write_pixel = (r_p_cov != 8'd0);
        if (r_p_cov == 8'd0 || r_p_alpha == 8'd0) begin
            n_o_item.blended_color = r_p_dst;
        end else if (r_p_alpha == 8'hFF) begin
            n_o_item.blended_color = r_p_src;
        end else begin
            n_o_item.blended_color = {q_r[4:0], q_g, q_b[4:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid <= i_valid;
            r_p_valid <= r_c_valid;
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c_cov   <= n_c_cov;
            r_c_alpha <= i_data.pix.alpha;
            r_c_src   <= i_data.pix.source_color;
            r_c_dst   <= i_data.pix.dest_color;
            r_p_cov   <= r_c_cov;
            r_p_alpha <= y[23:16];
            r_p_src   <= r_c_src;
            r_p_dst   <= r_c_dst;
            r_o_item  <= n_o_item;
        end
    end

    assign o_valid = r_o_valid;
    assign o_item  = r_o_item;

endmodule

[rtl/antialiased_corner_pixel_blend.sv]
// ----------------------------------------------------------------------------
// Antialiased corner pixel blend
// Coverage of one rounded corner pixel from a chain of square root cells,
// followed by alpha scaling and an RGB565 blend.
//
//   Channel | Direction | Signals                                  | Accepted when
//   in      | input     | i_in_valid, o_in_ready, i_in_item        | valid && ready
//   out     | output    | o_out_valid, i_out_ready, o_out_item     | valid && ready
//
// One item enters per cycle while the output is not stalled.
// Each item passes the input register, twelve root cells and three blend stages.
// Reset is synchronous and empties every stage at once.
// A stalled output holds the whole chain, so o_in_ready is i_out_ready while the output is valid and high otherwise.
// ----------------------------------------------------------------------------
module antialiased_corner_pixel_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  acpb_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output acpb_pkg::t_out_item o_out_item
);

    logic                      adv;
    logic                      r_s0_valid;
    acpb_pkg::t_cell           r_s0_data;
    acpb_pkg::t_cell           n_s0_data;
    logic [13:0]               sq_x;
    logic [13:0]               sq_y;
    logic [14:0]               sq_sum;
    logic [acpb_pkg::CELLS:0]  w_valid;
    acpb_pkg::t_cell           w_data [acpb_pkg::CELLS+1];

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_comb begin
        sq_x   = i_in_item.corner_dx * i_in_item.corner_dx;
        sq_y   = i_in_item.corner_dy * i_in_item.corner_dy;
        sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
        n_s0_data      = '0;
        n_s0_data.pix  = i_in_item;
        n_s0_data.rad  = {1'b0, sq_sum, 8'h00};
        if ({1'b0, i_in_item.radius} > acpb_pkg::MAX_RADIUS) begin
            n_s0_data.pix.radius = acpb_pkg::MAX_RADIUS[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_data <= n_s0_data;
        end
    end

    assign w_valid[0] = r_s0_valid;
    assign w_data[0]  = r_s0_data;

    for (genvar g = 0; g < acpb_pkg::CELLS; g++) begin : g_cell
        acpb_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    acpb_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (w_valid[acpb_pkg::CELLS]),
        .i_data  (w_data[acpb_pkg::CELLS]),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

[rtl/acpb_checker.sv]
// ----------------------------------------------------------------------------
// Corner blend port checker
// Port level checks of the corner blend, bound to the top level.
// ----------------------------------------------------------------------------
`include "antialiased_corner_pixel_blend_defines.svh"

module acpb_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input acpb_pkg::t_out_item i_out_item
);

    `ACPB_ASSERT(a_write_flag, i_clk, i_rst_n, i_out_valid |-> (i_out_item.write_pixel == (i_out_item.coverage != 8'd0)), "write flag disagrees with coverage")
    `ACPB_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with empty output")
    `ACPB_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_item)), "stalled output item changed")
    `ACPB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind antialiased_corner_pixel_blend acpb_checker u_acpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);
